### rtl/edq_pkg.sv
// ----------------------------------------------------------------------------
// edq_pkg
// Shared widths and register indexes of the error-diffusion quantiser.
// ----------------------------------------------------------------------------
package edq_pkg;

  // Widths of the port fields and configuration registers.
  localparam int PIX_W  = 16;
  localparam int GAIN_W = 25;
  localparam int BIAS_W = 32;
  localparam int OB_W   = 5;
  localparam int RW_W   = 13;
  localparam int OUT_W  = 16;

  // Scaled pixel: product of pixel and gain, then the sum with the bias.
  localparam int PROD_W = PIX_W + GAIN_W;
  localparam int X_W    = PROD_W + 2;

  // Register file port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_GAIN      = 2'd0,
    REG_BIAS      = 2'd1,
    REG_OUT_BITS  = 2'd2,
    REG_ROW_WIDTH = 2'd3
  } reg_idx_e;

endpackage

### rtl/error_diffusion_quantizer.sv
// ----------------------------------------------------------------------------
// error_diffusion_quantizer
// Floyd-Steinberg error diffusion of a raster pixel stream, left to right.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  ---------------------------
//  in        sink       in_valid_i / in_stall_o  pixel_value_i, frame_start_i
//  out       source     out_valid_o / out_stall_i out_value_o, row_end_o
//  config    slave      psel/penable/pready      paddr, pwdata, prdata
//
//  One pixel is taken per clock. A result leaves through the output register
//  once its pixel has passed the three pipeline stages.
//  Rows of four pixels or fewer run below the full rate, because the
//  line-buffer entry that a pixel needs is then still being written by a
//  pixel a few places ahead of it in the pipeline; the input is held off
//  until that write has landed. Wider rows run at the full rate.
//  The whole pipeline halts while a finished result waits under out_stall_i.
//  Reset clears all control state; the line buffer needs no clearing pass.
//
// The datapath is built around the error line buffer, a single-port-write,
// single-port-read memory with a registered read:
//
//  accept : the column and row flags are worked out and the upper-right
//           entry (column + 1) is read from the line buffer.
//  stage 1: the upper three weighted errors are summed (3, 5 and 1 sixteenths)
//           and the pixel is multiplied by the gain.
//  stage 2: the bias is added to the scaled pixel.
//  stage 3: the left error (7 sixteenths) closes the feedback loop; the value
//           is clamped, rounded to nearest with ties to even, and the residual
//           is written back to the line buffer and kept as the next left error.
//
// The upper window (upper-left and upper errors) is carried along from pixel
// to pixel, so that only one line-buffer read is needed per pixel. Column 0
// takes its upper error from a dedicated copy of entry 0.
// ----------------------------------------------------------------------------
module error_diffusion_quantizer #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [edq_pkg::PIX_W-1:0]     pixel_value_i,
  input  logic                          frame_start_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [edq_pkg::OUT_W-1:0]     out_value_o,
  output logic                          row_end_o,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [edq_pkg::APB_AW-1:0]    paddr,
  input  logic [edq_pkg::APB_DW-1:0]    pwdata,
  output logic [edq_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  // Column index width, residual width and the widths of the error sums.
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ERR_W  = FRAC_BITS + 2;
  localparam int PART_W = ERR_W + 3;
  localparam int W_W    = ERR_W + 4;
  localparam int V_W    = edq_pkg::X_W + 1;
  localparam int CL_W   = edq_pkg::OUT_W + FRAC_BITS;
  localparam int CMP_W  = (COL_W + 1 > edq_pkg::RW_W) ? (COL_W + 1) : edq_pkg::RW_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [edq_pkg::GAIN_W-1:0]        gain_q;
  logic signed [edq_pkg::BIAS_W-1:0] bias_q;
  logic [edq_pkg::OB_W-1:0]          out_bits_q;
  logic [edq_pkg::RW_W-1:0]          row_width_q;
  edq_pkg::reg_idx_e                 reg_idx;
  logic                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = edq_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= edq_pkg::GAIN_W'(65536);
      bias_q      <= '0;
      out_bits_q  <= edq_pkg::OB_W'(8);
      row_width_q <= edq_pkg::RW_W'(4096);
    end else if (cfg_wr) begin
      case (reg_idx)
        edq_pkg::REG_GAIN:      gain_q      <= pwdata[edq_pkg::GAIN_W-1:0];
        edq_pkg::REG_BIAS:      bias_q      <= $signed(pwdata[edq_pkg::BIAS_W-1:0]);
        edq_pkg::REG_OUT_BITS:  out_bits_q  <= pwdata[edq_pkg::OB_W-1:0];
        edq_pkg::REG_ROW_WIDTH: row_width_q <= pwdata[edq_pkg::RW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      edq_pkg::REG_GAIN:      prdata = edq_pkg::APB_DW'(gain_q);
      edq_pkg::REG_BIAS:      prdata = $unsigned(bias_q);
      edq_pkg::REG_OUT_BITS:  prdata = edq_pkg::APB_DW'(out_bits_q);
      edq_pkg::REG_ROW_WIDTH: prdata = edq_pkg::APB_DW'(row_width_q);
      default:                prdata = '0;
    endcase
  end

  // Out-of-range settings are folded into their legal range: a zero depth or
  // width acts as one, and anything beyond the maximum acts as the maximum.
  logic [CMP_W-1:0]         rw_ext;
  logic [CMP_W-1:0]         width_eff;
  logic [edq_pkg::OB_W-1:0] bits_eff;

  always_comb begin
    rw_ext = CMP_W'(row_width_q);
    if (rw_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = rw_ext;
    end
    if (out_bits_q == '0) begin
      bits_eff = edq_pkg::OB_W'(1);
    end else if (out_bits_q > edq_pkg::OB_W'(edq_pkg::OUT_W)) begin
      bits_eff = edq_pkg::OB_W'(edq_pkg::OUT_W);
    end else begin
      bits_eff = out_bits_q;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  // The whole pipeline moves as one: it halts only while the output register
  // holds a beat that the sink is stalling.
  logic advance;
  logic hazard;
  logic accept;

  logic             s1_valid_q, s2_valid_q, s3_valid_q;
  logic [COL_W-1:0] s1_col_q, s2_col_q, s3_col_q;
  logic             out_valid_q;

  assign advance    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~advance | hazard;
  assign accept     = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Accept: position in the row and the line-buffer read
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] column_q;
  logic             first_row_q;

  logic [COL_W-1:0] in_col;
  logic             in_first;
  logic [CMP_W-1:0] col_inc;
  logic             in_last;
  logic [COL_W-1:0] rd_addr;
  logic             need_ur;
  logic             need_up0;

  always_comb begin
    in_col   = frame_start_i ? '0 : column_q;
    in_first = frame_start_i | first_row_q;
    col_inc  = CMP_W'(in_col) + CMP_W'(1);
    in_last  = (col_inc >= width_eff);
    rd_addr  = col_inc[COL_W-1:0];
    // The upper-right error is read from the line buffer; the upper error of
    // column 0 comes from the copy of entry 0.
    need_ur  = ~in_first & ~in_last;
    need_up0 = (in_col == '0) & ~in_first;
  end

  // A pixel whose line entry is still to be written by a pixel in flight is
  // held back until that write has reached the memory. This happens only for
  // rows of four pixels or fewer.
  always_comb begin
    hazard = 1'b0;
    if (s1_valid_q && ((need_ur && s1_col_q == rd_addr) || (need_up0 && s1_col_q == '0))) begin
      hazard = 1'b1;
    end
    if (s2_valid_q && ((need_ur && s2_col_q == rd_addr) || (need_up0 && s2_col_q == '0))) begin
      hazard = 1'b1;
    end
    if (s3_valid_q && ((need_ur && s3_col_q == rd_addr) || (need_up0 && s3_col_q == '0))) begin
      hazard = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      first_row_q <= 1'b1;
    end else if (accept) begin
      column_q    <= in_last ? '0 : rd_addr;
      first_row_q <= in_last ? 1'b0 : in_first;
    end
  end

  // --------------------------------------------------------------------------
  // Error line buffer
  // --------------------------------------------------------------------------
  logic [ERR_W-1:0] err_mem [MAX_WIDTH];
  logic [ERR_W-1:0] rd_data_q;
  logic             mem_wr;
  logic [ERR_W-1:0] res;

  assign mem_wr = advance & s3_valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      err_mem[s3_col_q] <= res;
    end
    if (advance) begin
      rd_data_q <= err_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: upper errors and gain
  // --------------------------------------------------------------------------
  logic [edq_pkg::PIX_W-1:0] s1_pix_q;
  logic                      s1_last_q;
  logic                      s1_first_q;
  logic                      s1_ur_en_q;
  logic                      s1_col0_q;

  logic [ERR_W-1:0] e0_q;
  logic [ERR_W-1:0] uw0_q;
  logic [ERR_W-1:0] uw1_q;

  logic signed [ERR_W-1:0]  up_right, up_mid, up_left;
  logic signed [PART_W-1:0] ur_x, up_x, ul_x;
  logic signed [PART_W-1:0] s1_part;
  logic [edq_pkg::PROD_W-1:0] s1_prod;

  always_comb begin
    up_right = s1_ur_en_q ? $signed(rd_data_q) : '0;
    if (s1_col0_q) begin
      up_mid  = s1_first_q ? '0 : $signed(e0_q);
      up_left = '0;
    end else begin
      up_mid  = $signed(uw1_q);
      up_left = $signed(uw0_q);
    end
    ur_x    = PART_W'(up_right);
    up_x    = PART_W'(up_mid);
    ul_x    = PART_W'(up_left);
    s1_part = (ur_x <<< 1) + ur_x + (up_x <<< 2) + up_x + ul_x;
    s1_prod = edq_pkg::PROD_W'(s1_pix_q) * edq_pkg::PROD_W'(gain_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pix_q   <= pixel_value_i;
      s1_col_q   <= in_col;
      s1_last_q  <= in_last;
      s1_first_q <= in_first;
      s1_ur_en_q <= need_ur;
      s1_col0_q  <= (in_col == '0);
    end
    // The upper window slides one column per pixel.
    if (advance && s1_valid_q) begin
      uw0_q <= $unsigned(up_mid);
      uw1_q <= $unsigned(up_right);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: bias
  // --------------------------------------------------------------------------
  logic [edq_pkg::PROD_W-1:0]     s2_prod_q;
  logic signed [PART_W-1:0]       s2_part_q;
  logic                           s2_last_q;
  logic                           s2_col0_q;
  logic signed [edq_pkg::X_W-1:0] s2_x;

  assign s2_x = $signed({2'b00, s2_prod_q}) + edq_pkg::X_W'(bias_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_prod_q <= s1_prod;
      s2_part_q <= s1_part;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
      s2_col0_q <= s1_col0_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: left error, clamp, rounding and residual
  // --------------------------------------------------------------------------
  logic signed [edq_pkg::X_W-1:0] s3_x_q;
  logic signed [PART_W-1:0]       s3_part_q;
  logic                           s3_last_q;
  logic                           s3_col0_q;
  logic [ERR_W-1:0]               left_q;

  logic signed [W_W-1:0]      left_x;
  logic signed [W_W-1:0]      part_x;
  logic signed [W_W-1:0]      w_sum;
  logic signed [W_W-1:0]      w_floor;
  logic signed [V_W-1:0]      v_sum;
  logic [V_W-1:0]             max_v;
  logic [CL_W-1:0]            v_clamp;
  logic [edq_pkg::OUT_W-1:0]  q_trunc;
  logic [FRAC_BITS-1:0]       frac;
  logic [FRAC_BITS-1:0]       half;
  logic                       round_up;
  logic [edq_pkg::OUT_W-1:0]  q_rnd;
  logic [ERR_W-1:0]           frac_x;

  always_comb begin
    // The left error is zero at the start of every row.
    left_x  = s3_col0_q ? '0 : W_W'($signed(left_q));
    part_x  = W_W'(s3_part_q);
    w_sum   = (left_x <<< 3) - left_x + part_x;
    w_floor = w_sum >>> 4;
    v_sum   = V_W'(s3_x_q) + V_W'(w_floor);

    max_v = ((V_W'(1) << bits_eff) - V_W'(1)) << FRAC_BITS;
    if (v_sum[V_W-1]) begin
      v_clamp = '0;
    end else if ($unsigned(v_sum) > max_v) begin
      v_clamp = max_v[CL_W-1:0];
    end else begin
      v_clamp = v_sum[CL_W-1:0];
    end

    // Round to nearest, ties to even. The clamp keeps the rounded value in
    // range, so the increment never overflows.
    q_trunc  = v_clamp[CL_W-1:FRAC_BITS];
    frac     = v_clamp[FRAC_BITS-1:0];
    half     = FRAC_BITS'(1) << (FRAC_BITS - 1);
    round_up = (frac > half) | ((frac == half) & q_trunc[0]);
    q_rnd    = q_trunc + edq_pkg::OUT_W'(round_up);

    frac_x = {2'b00, frac};
    res    = round_up ? (frac_x - (ERR_W'(1) << FRAC_BITS)) : frac_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_x_q    <= s2_x;
      s3_part_q <= s2_part_q;
      s3_col_q  <= s2_col_q;
      s3_last_q <= s2_last_q;
      s3_col0_q <= s2_col0_q;
    end
    if (mem_wr) begin
      left_q <= res;
      if (s3_col_q == '0) begin
        e0_q <= res;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [edq_pkg::OUT_W-1:0] out_value_q;
  logic                      row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      out_value_q <= q_rnd;
      row_end_q   <= s3_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign row_end_o   = row_end_q;

endmodule

### rtl/edq_checker.sv
// ----------------------------------------------------------------------------
// edq_checker
// Port-level checks of the error-diffusion quantiser, bound to the top level.
// ----------------------------------------------------------------------------
module edq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [edq_pkg::PIX_W-1:0]     pixel_value_i,
  input logic                          frame_start_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [edq_pkg::OUT_W-1:0]     out_value_o,
  input logic                          row_end_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [edq_pkg::APB_AW-1:0]    paddr,
  input logic [edq_pkg::APB_DW-1:0]    pwdata,
  input logic [edq_pkg::APB_DW-1:0]    prdata,
  input logic                          pready
);

  // Beats accepted but not yet delivered.
  logic [2:0] pending_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i & ~in_stall_o;
  assign out_beat = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o) && $stable(row_end_o))
    else $error("result beat changed while stalled");

  // Three pipeline stages and the output register bound the pixels in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pending_q <= 3'd4)
    else $error("more pixels in flight than the pipeline holds");

  // No result without a pixel behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> pending_q != 3'd0)
    else $error("result beat without an accepted pixel");

  // An empty block takes a pixel at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && pending_q == 3'd0 |-> !in_stall_o)
    else $error("idle block stalls its input");

endmodule

bind error_diffusion_quantizer edq_checker u_edq_checker (.*);

### sim/tb_error_diffusion_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_error_diffusion_quantizer
// Self-checking testbench for the Floyd-Steinberg error-diffusion quantiser.
// A cycle-free predictor keeps its own copy of the line buffer, the error
// window and the register settings. It works out the quantised sample and
// the row-end flag of every pixel beat accepted on the input channel. A
// checker compares each output beat with the oldest prediction. Stimulus
// runs through directed cases first and then random frames under a range of
// register settings, with bursty input traffic and output back-pressure.
// ----------------------------------------------------------------------------
module tb_error_diffusion_quantizer;
  import edq_pkg::*;

  localparam int MAX_WIDTH     = 4096;
  localparam int FRAC_BITS     = 16;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int RANDOM_PIXELS = 1175;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 8;
  localparam int REPORT_LIMIT  = 10;

  // Residuals carry FRAC_BITS fraction bits and stay within +-0.5, so 18
  // signed bits hold them with room to spare.
  typedef logic signed [17:0] residual_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             row_end;
  } quant_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_value_i;
  logic                 frame_start_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [OUT_W-1:0]     out_value_o;
  logic                 row_end_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // Shadow copy of the register file, as the predictor sees it.
  logic [GAIN_W-1:0]        gain_q;
  logic signed [BIAS_W-1:0] bias_q;
  logic [OB_W-1:0]          out_bits_q;
  logic [RW_W-1:0]          row_width_q;

  // Predictor state: the line buffer of residuals from the row above, the
  // left residual, the upper-left/upper window and the scan position.
  residual_t        line_errors [MAX_WIDTH];
  residual_t        left_err;
  residual_t        upper_left_err;
  residual_t        upper_err;
  logic [COL_W-1:0] column_q;
  logic             first_row_q;

  // Number of leading line-buffer entries written since reset. Rows always
  // write from column 0 upwards, so the written entries form one run.
  int unsigned      line_extent;
  // Set when a wider row could read entries never written; the next pixel
  // then opens a new frame so that its first row reads no line errors.
  bit               need_frame_start;

  quant_result_t    expected_quantised [$];
  int               mismatch_count;
  int               burst_left;
  bit               steady_sender;
  int               idle_cycles;
  int               stall_span;
  int               stall_mode;

  error_diffusion_quantizer #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_value_o   (out_value_o),
    .row_end_o     (row_end_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Row widths of zero act as one, and widths beyond the line buffer act as
  // the full buffer.
  function automatic int unsigned clamp_width(logic [RW_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  // Quantises one pixel and advances the scan state. All sums are taken in
  // 64 bits, which is wide enough for the scaled pixel plus the bias.
  function automatic quant_result_t quantize_pixel(logic [PIX_W-1:0] pix,
                                                   logic first_of_frame);
    int unsigned   bits;
    int unsigned   row_len;
    int unsigned   col;
    logic          last;
    longint        left, up_left, up, up_right;
    longint        scaled, weighted, v, maxv, q, frac, half;
    quant_result_t res;

    if (first_of_frame) begin
      column_q       = '0;
      first_row_q    = 1'b1;
      left_err       = '0;
      upper_left_err = '0;
      upper_err      = '0;
    end

    if (out_bits_q == 0) bits = 1;
    else if (out_bits_q > OUT_W) bits = OUT_W;
    else bits = out_bits_q;
    row_len = clamp_width(row_width_q);

    // A column at or beyond the row length (the width was lowered mid-row)
    // closes the row as well.
    col  = column_q;
    last = (col + 1 >= row_len);

    // Column 0 has nothing to its upper left; the first row of a frame and
    // the last column see no error from the row above on the right.
    if (col == 0) begin
      up_left = 0;
      if (first_row_q) up = 0;
      else up = line_errors[0];
    end else begin
      up_left = upper_left_err;
      up      = upper_err;
    end
    if (first_row_q || last) up_right = 0;
    else up_right = line_errors[(col + 1) % MAX_WIDTH];
    left = left_err;

    scaled   = longint'(pix) * longint'(gain_q) + longint'(bias_q);
    weighted = 7 * left + 3 * up_right + 5 * up + up_left;
    v        = scaled + (weighted >>> 4);

    maxv = ((longint'(1) << bits) - 1) << FRAC_BITS;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;

    // Round to nearest, ties to even.
    half = longint'(1) << (FRAC_BITS - 1);
    q    = v >>> FRAC_BITS;
    frac = v - (q << FRAC_BITS);
    if (frac > half || (frac == half && q[0])) q = q + 1;

    line_errors[col] = residual_t'(v - (q << FRAC_BITS));
    if (col + 1 > line_extent) line_extent = col + 1;

    res.value   = q[OUT_W-1:0];
    res.row_end = last;

    if (last) begin
      column_q       = '0;
      first_row_q    = 1'b0;
      left_err       = '0;
      upper_left_err = '0;
      upper_err      = '0;
    end else begin
      left_err       = line_errors[col];
      upper_left_err = residual_t'(up);
      upper_err      = residual_t'(up_right);
      column_q       = COL_W'(col + 1);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Sends one pixel beat. The sender works in bursts; between bursts it may
  // drop valid for a random gap. Valid stays high from one beat to the next
  // inside a burst, and the payload only changes once the beat is taken.
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic first_of_frame);
    int gap;
    if (need_frame_start) begin
      first_of_frame   = 1'b1;
      need_frame_start = 1'b0;
    end
    if (burst_left == 0) begin
      if (steady_sender) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 30);
      else gap = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    frame_start_i <= first_of_frame;
    do begin
      @(posedge clk_i);
    end while (in_stall_o !== 1'b0);
    expected_quantised.push_back(quantize_pixel(pix, first_of_frame));
  endtask

  // Holds the input back until every predicted result has been seen. This is
  // also where the sender pauses under full drain, not only before writes.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do begin
      @(posedge clk_i);
    end while (expected_quantised.size() != 0);
  endtask

  // APB write: a setup phase, then the access phase until pready is seen.
  task automatic write_register(reg_idx_e idx, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN:      gain_q     = data[GAIN_W-1:0];
      REG_BIAS:      bias_q     = data[BIAS_W-1:0];
      REG_OUT_BITS:  out_bits_q = data[OB_W-1:0];
      REG_ROW_WIDTH: begin
        row_width_q = data[RW_W-1:0];
        if (clamp_width(row_width_q) > line_extent) need_frame_start = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Drains the block and then rewrites all four registers.
  task automatic configure(logic [GAIN_W-1:0] gain, logic [BIAS_W-1:0] bias,
                           logic [OB_W-1:0] depth, logic [RW_W-1:0] row_len);
    wait_for_results();
    write_register(REG_GAIN,      APB_DW'(gain));
    write_register(REG_BIAS,      APB_DW'(bias));
    write_register(REG_OUT_BITS,  APB_DW'(depth));
    write_register(REG_ROW_WIDTH, APB_DW'(row_len));
  endtask

  // --------------------------------------------------------------------------
  // Output back-pressure: the receiver switches between segments of no
  // stall, light random stall, heavy random stall and one solid stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = (stall_mode == 3) ? $urandom_range(3, 40) : $urandom_range(16, 160);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Checker: every output beat is compared with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    quant_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_quantised.size() == 0) begin
        note_mismatch($sformatf("output beat with nothing expected: value %0d, row end %0b",
                                out_value_o, row_end_o));
      end else begin
        want = expected_quantised.pop_front();
        if (out_value_o !== want.value)
          note_mismatch($sformatf("out_value: expected %0d, got %0d",
                                  want.value, out_value_o));
        if (row_end_o !== want.row_end)
          note_mismatch($sformatf("row_end: expected %0b, got %0b",
                                  want.row_end, row_end_o));
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL error_diffusion_quantizer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Settings straight out of reset: unity gain, 8-bit output, full width.
  // Full scale saturates at 255 and leaves no residual.
  task automatic test_reset_state();
    send_pixel(16'd0, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
  endtask

  // Register and field extremes, depth and width outside their range, and
  // exact halves to check that ties round to even.
  task automatic test_register_extremes();
    configure('1, 32'h7FFF_FFFF, 5'd16, 13'd1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'd0, 1'b0);
    configure('0, 32'h8000_0000, 5'd0, 13'd0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'd1, 1'b0);
    // 2.5 rounds down to 2, 3.5 rounds up to 4; each opens its own frame so
    // that no diffused error disturbs the tie.
    configure(GAIN_W'(65536), 32'h0000_8000, 5'd31, 13'd8191);
    send_pixel(16'd2, 1'b1);
    send_pixel(16'd3, 1'b1);
  endtask

  // Three-pixel rows: the first row of a frame sees no upper errors, later
  // rows see the row above with the borders reading zero, and a frame start
  // in mid-row clears the history.
  task automatic test_frame_borders();
    configure(GAIN_W'(3855), '0, 5'd4, 13'd3);
    send_pixel(16'd200, 1'b1);
    send_pixel(16'd17, 1'b0);
    send_pixel(16'd90, 1'b0);
    send_pixel(16'd33, 1'b0);
    send_pixel(16'd250, 1'b0);
    send_pixel(16'd128, 1'b0);
    send_pixel(16'd77, 1'b0);
    send_pixel(16'd140, 1'b1);
  endtask

  // The width drops below the current column mid-row, so the next pixel
  // ends its row; then the width goes back up and the row reads line
  // entries left over from the longer first row.
  task automatic test_width_lowered();
    configure(GAIN_W'(21845), 32'h0000_3000, 5'd3, 13'd5);
    send_pixel(16'd20, 1'b1);
    send_pixel(16'd7, 1'b0);
    send_pixel(16'd13, 1'b0);
    send_pixel(16'd1, 1'b0);
    wait_for_results();
    write_register(REG_ROW_WIDTH, APB_DW'(2));
    send_pixel(16'd11, 1'b0);
    send_pixel(16'd19, 1'b0);
    send_pixel(16'd4, 1'b0);
    wait_for_results();
    write_register(REG_ROW_WIDTH, APB_DW'(5));
    send_pixel(16'd16, 1'b0);
    send_pixel(16'd9, 1'b0);
  endtask

  // Random phases. Each phase picks register settings, mostly narrow rows
  // and a gain matched to the pixel range and output depth, then sends
  // whole frames of random pixels. A few stray frame starts break frames
  // up, and some phases carry on the frame of the phase before.
  task automatic test_random_frames();
    int unsigned      sent, limit, row_len, rows, depth, eff_depth, pix_max, spread;
    longint           gain_l, bias_l;
    logic [RW_W-1:0]  width_reg;
    logic [PIX_W-1:0] pix;
    bit               resume;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 15))
        0:       depth = 0;
        1:       depth = $urandom_range(17, 31);
        default: depth = $urandom_range(1, 16);
      endcase
      eff_depth = (depth == 0) ? 1 : (depth > OUT_W) ? OUT_W : depth;

      case ($urandom_range(0, 15))
        0:       width_reg = '0;
        1:       width_reg = RW_W'($urandom_range(MAX_WIDTH + 1, (1 << RW_W) - 1));
        2, 3:    width_reg = RW_W'($urandom_range(65, 200));
        4, 5, 6: width_reg = RW_W'($urandom_range(13, 64));
        default: width_reg = RW_W'($urandom_range(1, 12));
      endcase
      row_len = clamp_width(width_reg);

      pix_max = $urandom_range(0, 1) ? 255 : 65535;

      case ($urandom_range(0, 7))
        0:       gain_l = longint'($urandom_range(0, (1 << GAIN_W) - 1));
        1:       gain_l = longint'($urandom_range(0, 1 << 17));
        2:       gain_l = $urandom_range(0, 1) ? ((1 << GAIN_W) - 1) : 0;
        default: begin
          // Maps the pixel range onto the output range, give or take an
          // eighth, so that most pixels land inside the clamp limits.
          gain_l = (((longint'(1) << eff_depth) - 1) << FRAC_BITS) / pix_max;
          spread = gain_l / 8;
          gain_l = gain_l + longint'($urandom_range(0, 2 * spread)) - spread;
          if (gain_l > (1 << GAIN_W) - 1) gain_l = (1 << GAIN_W) - 1;
          if (gain_l < 0) gain_l = 0;
        end
      endcase

      if ($urandom_range(0, 5) == 0) bias_l = longint'($urandom());
      else bias_l = longint'($urandom_range(0, 1 << 18)) - (1 << 17);

      configure(gain_l[GAIN_W-1:0], bias_l[BIAS_W-1:0], depth[OB_W-1:0], width_reg);
      steady_sender = ($urandom_range(0, 3) == 0);
      resume        = ($urandom_range(0, 3) == 0);

      if (row_len > 64 && row_len < MAX_WIDTH)
        limit = sent + row_len + $urandom_range(10, 80);
      else
        limit = sent + $urandom_range(40, 160);

      while (sent < limit && sent < RANDOM_PIXELS) begin
        rows = $urandom_range(1, 4);
        for (int i = 0; i < rows * row_len && sent < limit; i++) begin
          case ($urandom_range(0, 15))
            0:       pix = '0;
            1:       pix = PIX_W'(pix_max);
            default: pix = PIX_W'($urandom_range(0, pix_max));
          endcase
          send_pixel(pix, (i == 0 && !resume) || ($urandom_range(0, 63) == 0));
          sent++;
        end
        resume = 1'b0;
        if ($urandom_range(0, 5) == 0) wait_for_results();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    pixel_value_i <= '0;
    frame_start_i <= 1'b0;
    out_stall_i   <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    // Register values and scan state after reset.
    gain_q           = GAIN_W'(65536);
    bias_q           = '0;
    out_bits_q       = OB_W'(8);
    row_width_q      = RW_W'(4096);
    column_q         = '0;
    first_row_q      = 1'b1;
    left_err         = '0;
    upper_left_err   = '0;
    upper_err        = '0;
    line_extent      = 0;
    need_frame_start = 1'b0;
    mismatch_count   = 0;
    burst_left       = 0;
    steady_sender    = 1'b0;
    idle_cycles      = 0;
    stall_span       = 0;
    stall_mode       = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_frame_borders();
    test_width_lowered();
    test_random_frames();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_quantised.size() == 0) begin
      $display("PASS error_diffusion_quantizer");
    end else begin
      $display("FAIL error_diffusion_quantizer");
    end
    $finish;
  end

endmodule

### sim.f
rtl/edq_pkg.sv
rtl/error_diffusion_quantizer.sv
rtl/edq_checker.sv
sim/tb_error_diffusion_quantizer.sv
